// ===== rtl/core/mfu_pkg.sv =====
// Package for the motor feedback unwrap block: slot count, identifier base and
// wrap constants. No dependencies.
`timescale 1ns / 1ps

package mfu_pkg;

	localparam int MOTOR_SLOTS = 9;
	localparam int SLOT_W      = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

	localparam logic [10:0] SLOT_BASE = 11'h204;

	// Angle difference plus one wrap correction fits in 18 signed bits
	localparam int DIFF_W = 18;

	localparam logic signed [DIFF_W-1:0] WRAP_HI   = DIFF_W'(4095);
	localparam logic signed [DIFF_W-1:0] WRAP_LO   = -DIFF_W'(4095);
	localparam logic signed [DIFF_W-1:0] TURN_SPAN = DIFF_W'(8192);

endpackage

// ===== rtl/core/mfu_frame_if.sv =====
// Valid/ready channel carrying one motor feedback frame.
// Depends on nothing.
`timescale 1ns / 1ps

interface mfu_frame_if;
	logic        valid;
	logic        ready;
	logic [10:0] frame_id;
	logic [7:0]  angle_high;
	logic [7:0]  angle_low;
	logic [7:0]  speed_high;
	logic [7:0]  speed_low;
	logic [7:0]  torque_high;
	logic [7:0]  torque_low;

	modport source (
		output valid, frame_id, angle_high, angle_low, speed_high, speed_low,
		       torque_high, torque_low,
		input  ready
	);
	modport sink (
		input  valid, frame_id, angle_high, angle_low, speed_high, speed_low,
		       torque_high, torque_low,
		output ready
	);
	modport monitor (
		input valid, ready, frame_id, angle_high, angle_low, speed_high, speed_low,
		      torque_high, torque_low
	);
endinterface

// ===== rtl/core/mfu_result_if.sv =====
// Valid/ready channel carrying one unwrapped feedback result.
// Depends on nothing.
`timescale 1ns / 1ps

interface mfu_result_if;
	logic               valid;
	logic               ready;
	logic               slot_valid;
	logic [3:0]         slot_index;
	logic signed [13:0] angle_step;
	logic signed [31:0] turn_total;
	logic signed [15:0] speed_value;
	logic signed [15:0] torque_value;

	modport source (
		output valid, slot_valid, slot_index, angle_step, turn_total, speed_value,
		       torque_value,
		input  ready
	);
	modport sink (
		input  valid, slot_valid, slot_index, angle_step, turn_total, speed_value,
		       torque_value,
		output ready
	);
	modport monitor (
		input valid, ready, slot_valid, slot_index, angle_step, turn_total,
		      speed_value, torque_value
	);
endinterface

// ===== rtl/core/motor_feedback_unwrap.sv =====
// Motor feedback unwrap: per-slot multi-turn angle accumulator.
// Depends on mfu_pkg, mfu_frame_if and mfu_result_if.
//
// Usage:
//   frame  : sink channel, one feedback frame per item (identifier and six
//            payload bytes). Identifiers 0x204 .. 0x204+MOTOR_SLOTS-1 select a
//            motor slot; any other identifier gives a result with slot_valid
//            low, all other fields zero, and leaves the state untouched.
//   result : source channel, exactly one item per accepted frame, in order.
//   Pipeline: a frame moves from the input register into the result register,
//            where result becomes valid. Throughput: one item per cycle while
//            result is not held, set by the single read-modify-write of the
//            slot's angle and turn registers, which is done as the item moves
//            from the input register to the result register.
//   Reset  : arst_n low clears both pipeline stages, every stored angle and
//            every turn total. A stored angle of zero means no previous
//            sample, so the next frame of that slot adds nothing.
//   Stall  : while result is held, the result register keeps its item and the
//            input register can still take one more frame; frame.ready drops
//            only when both are full.
`timescale 1ns / 1ps

module motor_feedback_unwrap (
	input  logic            clk,
	input  logic            arst_n,
	mfu_frame_if.sink       frame,
	mfu_result_if.source    result
);

	// Input stage
	logic        valid_s1;
	logic [10:0] frame_id_s1;
	logic [15:0] angle_s1;
	logic [15:0] speed_s1;
	logic [15:0] torque_s1;

	// Result stage
	logic               valid_s2;
	logic               slot_valid_s2;
	logic [3:0]         slot_index_s2;
	logic signed [13:0] angle_step_s2;
	logic signed [31:0] turn_total_s2;
	logic signed [15:0] speed_s2;
	logic signed [15:0] torque_s2;

	// Per-slot state
	logic [15:0] last_angle_q [mfu_pkg::MOTOR_SLOTS];
	logic [31:0] angle_sum_q  [mfu_pkg::MOTOR_SLOTS];

	logic                              advance;
	logic [10:0]                       offset;
	logic                              hit;
	logic [mfu_pkg::SLOT_W-1:0]        slot;
	logic [15:0]                       prev_angle;
	logic signed [mfu_pkg::DIFF_W-1:0] cur_ext;
	logic signed [mfu_pkg::DIFF_W-1:0] prev_ext;
	logic signed [mfu_pkg::DIFF_W-1:0] raw_diff;
	logic signed [mfu_pkg::DIFF_W-1:0] fix_hi;
	logic signed [mfu_pkg::DIFF_W-1:0] diff;
	logic [31:0]                       sum_next;

	assign advance     = !valid_s2 || result.ready;
	assign frame.ready = !valid_s1 || advance;

	always_comb begin
		offset     = frame_id_s1 - mfu_pkg::SLOT_BASE;
		hit        = (frame_id_s1 >= mfu_pkg::SLOT_BASE) &&
		             (offset < 11'(mfu_pkg::MOTOR_SLOTS));
		slot       = offset[mfu_pkg::SLOT_W-1:0];
		prev_angle = last_angle_q[slot];
		cur_ext    = {{(mfu_pkg::DIFF_W-16){angle_s1[15]}}, angle_s1};
		prev_ext   = {{(mfu_pkg::DIFF_W-16){prev_angle[15]}}, prev_angle};
		raw_diff   = cur_ext - prev_ext;
		// Corrections apply in order: the second sees the first's result
		fix_hi     = (raw_diff >= mfu_pkg::WRAP_HI) ? raw_diff - mfu_pkg::TURN_SPAN
		                                            : raw_diff;
		if (prev_angle == 16'd0) begin
			diff = '0;
		end else if (fix_hi <= mfu_pkg::WRAP_LO) begin
			diff = fix_hi + mfu_pkg::TURN_SPAN;
		end else begin
			diff = fix_hi;
		end
		sum_next = angle_sum_q[slot] + {{(32-mfu_pkg::DIFF_W){diff[mfu_pkg::DIFF_W-1]}}, diff};
	end

	// Control and per-slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < mfu_pkg::MOTOR_SLOTS; i++) begin
				last_angle_q[i] <= '0;
				angle_sum_q[i]  <= '0;
			end
		end else begin
			if (frame.ready) begin
				valid_s1 <= frame.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			// Update the slot as its item moves into the result register
			if (advance && valid_s1 && hit) begin
				last_angle_q[slot] <= angle_s1;
				angle_sum_q[slot]  <= sum_next;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			frame_id_s1 <= frame.frame_id;
			angle_s1    <= {frame.angle_high, frame.angle_low};
			speed_s1    <= {frame.speed_high, frame.speed_low};
			torque_s1   <= {frame.torque_high, frame.torque_low};
		end
		if (advance && valid_s1) begin
			slot_valid_s2 <= hit;
			if (hit) begin
				slot_index_s2 <= 4'(slot);
				angle_step_s2 <= diff[13:0];
				turn_total_s2 <= sum_next;
				speed_s2      <= speed_s1;
				torque_s2     <= torque_s1;
			end else begin
				slot_index_s2 <= '0;
				angle_step_s2 <= '0;
				turn_total_s2 <= '0;
				speed_s2      <= '0;
				torque_s2     <= '0;
			end
		end
	end

	assign result.valid        = valid_s2;
	assign result.slot_valid   = slot_valid_s2;
	assign result.slot_index   = slot_index_s2;
	assign result.angle_step   = angle_step_s2;
	assign result.turn_total   = turn_total_s2;
	assign result.speed_value  = speed_s2;
	assign result.torque_value = torque_s2;

endmodule

// ===== rtl/core/mfu_checker.sv =====
// Port-level checks for motor_feedback_unwrap, attached by bind.
// Depends on mfu_pkg and the channel signals of motor_feedback_unwrap.
`timescale 1ns / 1ps

module mfu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        frame_valid,
	input logic        frame_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic        slot_valid,
	input logic [3:0]  slot_index,
	input logic [13:0] angle_step,
	input logic [31:0] turn_total,
	input logic [15:0] speed_value,
	input logic [15:0] torque_value
);

	// A held result keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(turn_total) &&
		$stable(slot_index) && $stable(slot_valid))
		else $error("result item changed while stalled");

	// Input backpressure only when both stages are full and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!frame_ready |-> result_valid && !result_ready)
		else $error("frame stalled without output backpressure");

	// Unmapped identifiers give an all-zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !slot_valid |-> slot_index == 4'd0 &&
		angle_step == 14'd0 && turn_total == 32'd0 &&
		speed_value == 16'd0 && torque_value == 16'd0)
		else $error("unmapped frame produced nonzero fields");

	// Mapped slot index stays inside the slot range
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && slot_valid |->
		32'(slot_index) < 32'(mfu_pkg::MOTOR_SLOTS))
		else $error("slot index out of range");

endmodule

bind motor_feedback_unwrap mfu_checker u_mfu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.frame_valid  (frame.valid),
	.frame_ready  (frame.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.slot_valid   (result.slot_valid),
	.slot_index   (result.slot_index),
	.angle_step   (result.angle_step),
	.turn_total   (result.turn_total),
	.speed_value  (result.speed_value),
	.torque_value (result.torque_value)
);

// ===== tb/motor_feedback_unwrap_tb.sv =====
// Testbench for motor_feedback_unwrap: directed and random frames on the frame channel, random stalls on the
// result channel, and every result checked against an in-bench turn tracker.
// Depends on mfu_pkg, mfu_frame_if, mfu_result_if and the motor_feedback_unwrap RTL.
`timescale 1ns / 1ps

module motor_feedback_unwrap_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_FRAMES = 1525;
	localparam int MAX_IDLE = 16;

	typedef struct packed {
		logic [10:0] frame_id;
		logic [15:0] angle;
		logic [15:0] speed;
		logic [15:0] torque;
	} feedback_frame_t;

	typedef struct packed {
		logic        slot_valid;
		logic [3:0]  slot_index;
		logic [13:0] angle_step;
		logic [31:0] turn_total;
		logic [15:0] speed_value;
		logic [15:0] torque_value;
	} unwrap_result_t;

	// Per-slot angle history and turn totals; queues the result each frame must produce
	class turn_tracker;
		logic [15:0]    prev_angle [mfu_pkg::MOTOR_SLOTS];
		logic [31:0]    turn_sum [mfu_pkg::MOTOR_SLOTS];
		unwrap_result_t pending_results [$];
		int             slot_frames;
		int             unknown_frames;
		int             results_seen;
		int             failures;

		function new();
			foreach (prev_angle[i]) begin
				prev_angle[i] = '0;
				turn_sum[i] = '0;
			end
		endfunction

		function void note_frame(feedback_frame_t f);
			unwrap_result_t r;
			logic [10:0]    offs;
			int unsigned    slot;
			int             step;
			r = '0;
			offs = f.frame_id - mfu_pkg::SLOT_BASE;
			if (f.frame_id >= mfu_pkg::SLOT_BASE && offs < mfu_pkg::MOTOR_SLOTS) begin
				slot = offs;
				// a stored angle of zero means no previous sample: add nothing
				if (prev_angle[slot] == '0) begin
					step = 0;
				end else begin
					step = int'($signed(f.angle)) - int'($signed(prev_angle[slot]));
					if (step >= mfu_pkg::WRAP_HI)
						step -= mfu_pkg::TURN_SPAN;
					if (step <= mfu_pkg::WRAP_LO)
						step += mfu_pkg::TURN_SPAN;
				end
				turn_sum[slot] += step;
				prev_angle[slot] = f.angle;
				r.slot_valid = 1'b1;
				r.slot_index = slot[3:0];
				r.angle_step = step[13:0];
				r.turn_total = turn_sum[slot];
				r.speed_value = f.speed;
				r.torque_value = f.torque;
				slot_frames++;
			end else begin
				unknown_frames++;
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(unwrap_result_t got);
			unwrap_result_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("ERROR: result with no frame waiting: valid %b slot %0d total %0d",
						got.slot_valid, got.slot_index, $signed(got.turn_total));
				return;
			end
			want = pending_results.pop_front();
			results_seen++;
			if (got.slot_valid !== want.slot_valid || got.slot_index !== want.slot_index ||
				got.angle_step !== want.angle_step || got.turn_total !== want.turn_total ||
				got.speed_value !== want.speed_value ||
				got.torque_value !== want.torque_value) begin
				failures++;
				if (failures <= 10) begin
					$display("ERROR: result %0d mismatch", results_seen);
					$display("  got  valid %b slot %0d step %0d total %0d speed %0d torque %0d",
						got.slot_valid, got.slot_index, $signed(got.angle_step),
						$signed(got.turn_total), $signed(got.speed_value),
						$signed(got.torque_value));
					$display("  want valid %b slot %0d step %0d total %0d speed %0d torque %0d",
						want.slot_valid, want.slot_index, $signed(want.angle_step),
						$signed(want.turn_total), $signed(want.speed_value),
						$signed(want.torque_value));
				end
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mfu_frame_if  frame_ch ();
	mfu_result_if result_ch ();

	motor_feedback_unwrap dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch)
	);

	turn_tracker tracker = new();
	int          frames_sent;
	int          cycle_count;
	logic [15:0] stim_angle [mfu_pkg::MOTOR_SLOTS];

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Leaves valid high with the accepted item; the caller either sends the next one
	// at once or lowers valid.
	task automatic send_frame(input feedback_frame_t f);
		int gap;
		gap = ((frames_sent / 100) % 4 == 3) ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid       <= 1'b1;
		frame_ch.frame_id    <= f.frame_id;
		frame_ch.angle_high  <= f.angle[15:8];
		frame_ch.angle_low   <= f.angle[7:0];
		frame_ch.speed_high  <= f.speed[15:8];
		frame_ch.speed_low   <= f.speed[7:0];
		frame_ch.torque_high <= f.torque[15:8];
		frame_ch.torque_low  <= f.torque[7:0];
		do
			@(posedge clk);
		while (!frame_ch.ready);
		frames_sent++;
	endtask

	task automatic send_directed();
		feedback_frame_t f;
		send_frame({11'h204, 16'h1000, 16'h0000, 16'h0000}); // first sample of a slot
		send_frame({11'h204, 16'h1FFF, 16'hFFFF, 16'hFFFF}); // both corrections fire
		send_frame({11'h204, 16'h0001, 16'h7FFF, 16'h8000}); // forward past the seam
		send_frame({11'h204, 16'h0FFF, 16'h8000, 16'h7FFF}); // just under the upper bound
		send_frame({11'h204, 16'h0000, 16'h00FF, 16'hFF00}); // lower bound, store zero
		send_frame({11'h204, 16'h1234, 16'h0102, 16'h0304}); // after zero: no step
		send_frame({11'h204, 16'h0235, 16'h5555, 16'hAAAA}); // lower bound exactly
		send_frame({11'h204, 16'h7FFF, 16'hAAAA, 16'h5555}); // step wider than 14 bits
		send_frame({11'h204, 16'h8000, 16'h0001, 16'hFFFE}); // negative angle
		send_frame({11'h204, 16'hFFFF, 16'hFFFE, 16'h0001});
		send_frame({11'h20C, 16'h0100, 16'h1234, 16'h4321}); // last slot
		send_frame({11'h20C, 16'h1F00, 16'h4321, 16'h1234});
		send_frame({11'h203, 16'hFFFF, 16'hFFFF, 16'hFFFF}); // just below the slot range
		send_frame({11'h20D, 16'h1111, 16'h2222, 16'h3333}); // just above the slot range
		send_frame({11'h000, 16'h0000, 16'h0000, 16'h0000});
		send_frame({11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		for (int s = 1; s < mfu_pkg::MOTOR_SLOTS - 1; s++) begin
			f.frame_id = mfu_pkg::SLOT_BASE + 11'(s);
			f.angle    = 16'h0800 + 16'(s);
			f.speed    = 16'(s * 16'h1111);
			f.torque   = ~16'(s * 16'h1111);
			send_frame(f);
		end
		send_frame({11'h205, 16'h1801, 16'h0000, 16'hFFFF}); // forward by half a turn
	endtask

	task automatic send_random(input int count);
		feedback_frame_t f;
		int              near_wrap [8] = '{4094, 4095, 4096, -4094, -4095, -4096, 8191, -8191};
		int              slot;
		int              kind;
		int              pick;
		for (int i = 0; i < count; i++) begin
			// hold off once until the block has drained
			if (i == count / 2) begin
				frame_ch.valid <= 1'b0;
				@(posedge clk);
				while (tracker.pending() != 0)
					@(posedge clk);
			end
			f.speed  = 16'($urandom);
			f.torque = 16'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				f.frame_id = 11'($urandom_range(0, 2047));
				f.angle    = 16'($urandom);
			end else begin
				slot = $urandom_range(0, mfu_pkg::MOTOR_SLOTS - 1);
				f.frame_id = mfu_pkg::SLOT_BASE + 11'(slot);
				kind = $urandom_range(0, 9);
				case (kind)
					0: begin
						f.angle = 16'($urandom);
					end
					1: begin
						f.angle = '0;
					end
					2, 3, 4: begin
						f.angle = 16'((int'(stim_angle[slot]) + near_wrap[$urandom_range(0, 7)]
							+ int'($urandom_range(0, 2)) - 1) & 8191);
					end
					5: begin
						f.angle = 16'($urandom_range(0, 8191));
					end
					default: begin
						f.angle = 16'((int'(stim_angle[slot]) + int'($urandom_range(0, 400))
							- 200) & 8191);
					end
				endcase
				stim_angle[slot] = f.angle;
			end
			send_frame(f);
		end
	endtask

	initial begin
		int rx_count;
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = ((rx_count / 64) % 5 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!result_ch.valid);
			rx_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results outstanding",
				cycle_count, tracker.pending());
			$display("Verification failed");
			$finish;
		end else if (arst_n) begin
			if (frame_ch.valid && frame_ch.ready)
				tracker.note_frame({frame_ch.frame_id,
					frame_ch.angle_high, frame_ch.angle_low,
					frame_ch.speed_high, frame_ch.speed_low,
					frame_ch.torque_high, frame_ch.torque_low});
			if (result_ch.valid && result_ch.ready)
				tracker.check_result({result_ch.slot_valid, result_ch.slot_index,
					result_ch.angle_step, result_ch.turn_total,
					result_ch.speed_value, result_ch.torque_value});
		end
	end

	initial begin
		arst_n               = 1'b0;
		frame_ch.valid       = 1'b0;
		frame_ch.frame_id    = '0;
		frame_ch.angle_high  = '0;
		frame_ch.angle_low   = '0;
		frame_ch.speed_high  = '0;
		frame_ch.speed_low   = '0;
		frame_ch.torque_high = '0;
		frame_ch.torque_low  = '0;
		foreach (stim_angle[i])
			stim_angle[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		send_random(RANDOM_FRAMES);
		frame_ch.valid <= 1'b0;

		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d frames: %0d to motor slots, %0d with identifiers outside the range.",
			frames_sent, tracker.slot_frames, tracker.unknown_frames);
		$display("Checked %0d results, %0d failures, under random gaps and result stalls.",
			tracker.results_seen, tracker.failures);
		if (tracker.failures == 0 && tracker.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
